>>> sv/icrr_pkg.sv
// shared constants, codes and control types of the interleaved crossbar arbiter
`timescale 1ns / 1ps
package icrr_pkg;

    localparam int MASTERS    = 8;
    localparam int BANKS      = 8;
    localparam int ID_W       = 3;
    localparam int BANK_W     = 3;
    localparam int ADDR_W     = 32;
    localparam int IB_W       = 5;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int PTR_W      = $clog2(MASTERS);
    localparam int BANK_SHIFT = $clog2(BANKS);
    localparam logic [IB_W-1:0] IB_RESET = IB_W'(2);

    localparam logic [OP_W-1:0] OP_NEW     = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_REISSUE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DENIED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd2;

    typedef struct packed {
        logic load_in;
        logic emit_single;
        logic grant;
        logic bank_clr;
        logic bank_inc;
    } cmd_t;

    typedef struct packed {
        logic            cur_nonempty;
        logic            later_nonempty;
        logic            out_free;
    } sts_t;

endpackage

>>> sv/icrr_ctrl.sv
// controller state machine: input handshake and bank scan sequencing
`timescale 1ns / 1ps
module icrr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [icrr_pkg::OP_W-1:0] in_op,
    output logic                    in_ready,
    input  icrr_pkg::sts_t          sts,
    output icrr_pkg::cmd_t          cmd
);
    import icrr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    if (in_op == OP_TICK)
                    begin
                        cmd.bank_clr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else if (in_op == OP_NEW || in_op == OP_REISSUE)
                    begin
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.cur_nonempty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.grant = 1'b1;
                        if (sts.later_nonempty)
                        begin
                            cmd.bank_inc = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (sts.later_nonempty)
                begin
                    cmd.bank_inc = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a tick always enters the scan
    a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_TICK) |=> (state_reg == ST_SCAN))
        else $error("tick did not start the bank scan");

    // the grant from the last busy bank ends the scan
    a_last_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grant && !sts.later_nonempty) |=> (state_reg == ST_IDLE))
        else $error("scan went on past the last busy bank");

    // nothing is issued while a new beat is being taken
    a_no_cmd_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!cmd.grant && !cmd.emit_single))
        else $error("result issued in the accept cycle");

endmodule

>>> sv/icrr_dp.sv
// datapath: pending bits, round-robin pointers, address decode, result register
`timescale 1ns / 1ps
module icrr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [icrr_pkg::IB_W-1:0]     cfg_wdata,
    input  logic [icrr_pkg::OP_W-1:0]     in_op,
    input  logic [icrr_pkg::ID_W-1:0]     in_master_id,
    input  logic [icrr_pkg::ADDR_W-1:0]   in_address,
    input  icrr_pkg::cmd_t                cmd,
    output icrr_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [icrr_pkg::KIND_W-1:0]   out_kind,
    output logic [icrr_pkg::BANK_W-1:0]   out_bank_id,
    output logic [icrr_pkg::ID_W-1:0]     out_winner,
    output logic [icrr_pkg::ADDR_W-1:0]   out_bank_addr,
    output logic                          out_still_pending,
    output logic                          out_last
);
    import icrr_pkg::*;

    logic [IB_W-1:0]    ib_reg;
    logic [OP_W-1:0]    op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [MASTERS-1:0] pend_reg [BANKS];
    logic [PTR_W-1:0]   ptr_reg [BANKS];
    logic [BANK_W-1:0]  cnt_reg;
    logic               any_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [BANK_W-1:0]  bank_reg;
    logic [ID_W-1:0]    winner_reg;
    logic [ADDR_W-1:0]  offset_reg;
    logic               still_reg;
    logic               last_reg;

    logic [BANK_W-1:0]  dec_bank;
    logic [ADDR_W-1:0]  dec_offset;
    logic [ADDR_W-1:0]  low_mask;
    logic [5:0]         upper_shift;
    logic [BANKS-1:0]   nonempty;
    logic [BANKS-1:0]   later_mask;
    logic [MASTERS-1:0] cur_pend;
    logic [MASTERS-1:0] cur_pend_next;
    logic [PTR_W-1:0]   win;
    logic [PTR_W-1:0]   win_ptr_next;
    logic               set_bit;
    logic               out_free;
    logic               any_next;

    // address decode
    assign low_mask    = (ADDR_W'(1) << ib_reg) - ADDR_W'(1);
    assign upper_shift = 6'(BANK_SHIFT) + {1'b0, ib_reg};
    assign dec_bank    = BANK_W'(addr_reg >> ib_reg) & BANK_W'(BANKS - 1);
    assign dec_offset  = ((addr_reg >> upper_shift) << ib_reg) | (addr_reg & low_mask);

    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            nonempty[b]   = |pend_reg[b];
            later_mask[b] = (BANK_W'(b) > cnt_reg);
        end
    end

    assign cur_pend = pend_reg[cnt_reg];

    // round-robin pick starting at the bank pointer
    always_comb
    begin
        logic             found;
        logic [PTR_W:0]   sum;
        logic [PTR_W-1:0] idx;
        found = 1'b0;
        win   = '0;
        sum   = '0;
        idx   = '0;
        for (int i = 0; i < MASTERS; i++)
        begin
            sum = {1'b0, ptr_reg[cnt_reg]} + (PTR_W + 1)'(i);
            if (sum >= (PTR_W + 1)'(MASTERS))
            begin
                sum = sum - (PTR_W + 1)'(MASTERS);
            end
            idx = sum[PTR_W-1:0];
            if (!found && cur_pend[idx])
            begin
                found = 1'b1;
                win   = idx;
            end
        end
    end

    assign win_ptr_next  = (win == PTR_W'(MASTERS - 1)) ? '0 : win + PTR_W'(1);
    assign cur_pend_next = cur_pend & ~(MASTERS'(1) << win);
    assign any_next      = any_reg || (|cur_pend_next);
    assign set_bit       = cmd.emit_single && (op_reg == OP_NEW)
                           && (int'(id_reg) < MASTERS);

    assign out_free          = !out_valid_reg || out_ready;
    assign sts.cur_nonempty  = nonempty[cnt_reg];
    assign sts.later_nonempty = |(nonempty & later_mask);
    assign sts.out_free      = out_free;

    // configuration, scan state and arbitration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_reg  <= IB_RESET;
            cnt_reg <= '0;
            any_reg <= 1'b0;
            for (int b = 0; b < BANKS; b++)
            begin
                pend_reg[b] <= '0;
                ptr_reg[b]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                ib_reg <= cfg_wdata;
            end
            if (cmd.bank_clr)
            begin
                cnt_reg <= '0;
                any_reg <= 1'b0;
            end
            else if (cmd.bank_inc)
            begin
                cnt_reg <= cnt_reg + BANK_W'(1);
            end
            if (cmd.grant)
            begin
                any_reg <= any_next;
            end
            for (int b = 0; b < BANKS; b++)
            begin
                if (set_bit && dec_bank == BANK_W'(b))
                begin
                    pend_reg[b][id_reg[PTR_W-1:0]] <= 1'b1;
                end
                if (cmd.grant && cnt_reg == BANK_W'(b))
                begin
                    pend_reg[b] <= cur_pend_next;
                    ptr_reg[b]  <= win_ptr_next;
                end
            end
        end
    end

    // latched input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_NEW;
        end
        else if (cmd.load_in)
        begin
            op_reg <= in_op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            id_reg   <= in_master_id;
            addr_reg <= in_address;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_single || cmd.grant)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_single)
        begin
            kind_reg   <= (op_reg == OP_NEW) ? KIND_DENIED : KIND_FORWARD;
            bank_reg   <= dec_bank;
            winner_reg <= id_reg;
            offset_reg <= (op_reg == OP_NEW) ? '0 : dec_offset;
            still_reg  <= 1'b0;
            last_reg   <= 1'b1;
        end
        else if (cmd.grant)
        begin
            kind_reg   <= KIND_GRANT;
            bank_reg   <= cnt_reg;
            winner_reg <= ID_W'(win);
            offset_reg <= '0;
            still_reg  <= !sts.later_nonempty && any_next;
            last_reg   <= !sts.later_nonempty;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_kind          = kind_reg;
    assign out_bank_id       = bank_reg;
    assign out_winner        = winner_reg;
    assign out_bank_addr     = offset_reg;
    assign out_still_pending = still_reg;
    assign out_last          = last_reg;

    // a result is loaded only into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_single || cmd.grant) |-> out_free)
        else $error("result register overwritten");

    // grants only happen on a bank that has requests
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (sts.cur_nonempty && cur_pend[win]))
        else $error("grant on an empty bank");

    // each grant removes exactly one pending request from its bank
    a_grant_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> ($countones(cur_pend_next) + 1 == $countones(cur_pend)))
        else $error("grant did not clear exactly one request");

endmodule

>>> sv/interleaved_crossbar_rr_arbiter_core.sv
// top level of the bank-interleaved crossbar round-robin arbiter
`timescale 1ns / 1ps
// Takes one beat at a time. A new request or a re-issued request loads its one result
// beat into the output register from the ST_SINGLE state once the output is free.
// An election tick scans the banks one per cycle from bank 0, holding at a busy bank while
// the result side stalls, stops after the last bank with pending requests, and emits one
// grant beat per busy bank in ascending bank order. The next beat is taken once the
// previous one has loaded its last result, if any, into the output register.
// interleave_bits resets to 2 and may only be written while the block is idle.
module interleaved_crossbar_rr_arbiter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [icrr_pkg::IB_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [icrr_pkg::OP_W-1:0]       op,
    input  logic [icrr_pkg::ID_W-1:0]       master_id,
    input  logic [icrr_pkg::ADDR_W-1:0]     address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [icrr_pkg::KIND_W-1:0]     kind,
    output logic [icrr_pkg::BANK_W-1:0]     bank_id,
    output logic [icrr_pkg::ID_W-1:0]       winner,
    output logic [icrr_pkg::ADDR_W-1:0]     bank_addr,
    output logic                            still_pending,
    output logic                            last
);
    import icrr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    icrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    icrr_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_op             (op),
        .in_master_id      (master_id),
        .in_address        (address),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_kind          (kind),
        .out_bank_id       (bank_id),
        .out_winner        (winner),
        .out_bank_addr     (bank_addr),
        .out_still_pending (still_pending),
        .out_last          (last)
    );

endmodule
